### hdl/spq_pkg.sv
package spq_pkg;

	localparam int DataW = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [DataW-1:0] prio;
		logic [DataW-1:0] value;
	} entry_t;

	// row-wide command, already gated by fill state
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

### hdl/spq_cell.sv
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                held,
	input  spq_pkg::entry_t     new_entry,
	input  spq_pkg::entry_t     left_entry,
	input  logic                left_gt,
	input  spq_pkg::entry_t     right_entry,
	output spq_pkg::entry_t     entry,
	output logic                gt
);
	import spq_pkg::*;

	entry_t entry_q;

	// empty slots count as greater so a new item lands at the tail
	assign gt    = !held || ($signed(entry_q.prio) > $signed(new_entry.prio));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

### hdl/stable_priority_queue.sv
// Stable priority queue held in a sorted row of DEPTH cells.
// The result on m_tdata/m_tuser is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle unless m_tready stalls; each insert or remove is one
// shift of the cell row, and a new item is taken while the previous result is being taken.
// Reset (arst_n low, asynchronous): queue empty, no result pending; cell contents
// are left as they are and never read before being written.
module stable_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // in_value [31:0], in_priority [63:32]
	input  logic [0:0]  s_tuser,  // func [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // out_value [31:0], out_priority [63:32], fill_level [68:64]
	output logic [1:0]  m_tuser   // status [1:0]
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_next;
	logic            out_valid_q;
	logic [71:0]     out_data_q;
	status_t         out_status_q;
	logic            accept;
	op_t             op;
	logic            full;
	logic            empty;
	cell_ctrl_t      ctrl;
	status_t         status;
	entry_t          new_entry;
	entry_t          head;
	entry_t          cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_gt;
	logic [CW+4:0]   fill_ext;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign op        = op_t'(s_tuser[0]);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign new_entry = '{prio: s_tdata[63:32], value: s_tdata[31:0]};
	assign head      = cell_entry[0];

	always_comb begin
		ctrl       = '{ins: 1'b0, rem: 1'b0};
		count_next = count_q;
		status     = ST_INSERTED;
		if (op == OP_INSERT) begin
			if (full) begin
				status = ST_FULL;
			end else begin
				ctrl.ins   = accept;
				count_next = count_q + 1'b1;
				status     = ST_INSERTED;
			end
		end else begin
			if (empty) begin
				status = ST_EMPTY;
			end else begin
				ctrl.rem   = accept;
				count_next = count_q - 1'b1;
				status     = ST_REMOVED;
			end
		end
	end

	assign fill_ext = {5'b0, count_next};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.held        (count_q > CW'(i)),
			.new_entry   (new_entry),
			.left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
			.left_gt     ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
			.entry       (cell_entry[i]),
			.gt          (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_INSERTED;
		end else begin
			if (accept) begin
				count_q      <= count_next;
				out_valid_q  <= 1'b1;
				out_status_q <= status;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q[71:69] <= '0;
			out_data_q[68:64] <= fill_ext[4:0];
			if (status == ST_REMOVED) begin
				out_data_q[63:32] <= head.prio;
				out_data_q[31:0]  <= head.value;
			end else begin
				out_data_q[63:0] <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_INSERT && !full |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the queue");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[68:0] == '0)
		else $error("empty remove result not zero");

endmodule

### sim/spq_checker.sv
module spq_checker #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,  // in_value [31:0], in_priority [63:32]
	input  logic [0:0]  s_tuser,  // func [0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,  // out_value [31:0], out_priority [63:32], fill_level [68:64]
	input  logic [1:0]  m_tuser,  // status [1:0]
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	typedef struct packed {
		status_t          status;
		logic [DataW-1:0] value;
		logic [DataW-1:0] prio;
		logic [4:0]       fill;
	} reply_t;

	// shadow of the sorted row, head first
	entry_t held[$];
	reply_t due_replies[$];

	function automatic reply_t serve(input op_t op, input logic [DataW-1:0] value,
			input logic [DataW-1:0] prio);
		reply_t r;
		entry_t e;
		int     pos;
		int     i;
		r = '{status: ST_INSERTED, value: '0, prio: '0, fill: '0};
		if (op == OP_INSERT) begin
			if (held.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// goes behind every entry of lower or equal priority
				pos = held.size();
				for (i = 0; i < held.size(); i++) begin
					if ($signed(held[i].prio) > $signed(prio)) begin
						pos = i;
						break;
					end
				end
				e.prio = prio;
				e.value = value;
				held.insert(pos, e);
			end
		end else begin
			if (held.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				e = held.pop_front();
				r.status = ST_REMOVED;
				r.value = e.value;
				r.prio = e.prio;
			end
		end
		r.fill = 5'(held.size());
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			// compare first, so a stray result is never matched to this edge's item
			if (m_tvalid && m_tready) begin
				if (due_replies.size() == 0) begin
					$error("result with nothing outstanding: status %0d", m_tuser);
					mismatches++;
				end else begin
					want = due_replies.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						mismatches++;
					end
					if (m_tdata[31:0] !== want.value) begin
						$error("out_value: expected %0d, got %0d",
							$signed(want.value), $signed(m_tdata[31:0]));
						mismatches++;
					end
					if (m_tdata[63:32] !== want.prio) begin
						$error("out_priority: expected %0d, got %0d",
							$signed(want.prio), $signed(m_tdata[63:32]));
						mismatches++;
					end
					if (m_tdata[68:64] !== want.fill) begin
						$error("fill_level: expected %0d, got %0d", want.fill, m_tdata[68:64]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				due_replies.push_back(serve(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]));
			end
			pending <= due_replies.size();
		end
	end

endmodule

### sim/tb_stable_priority_queue.sv
module tb_stable_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int Depth = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // in_value [31:0], in_priority [63:32]
	logic [0:0]  s_tuser = '0;   // func [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // out_value [31:0], out_priority [63:32], fill_level [68:64]
	logic [1:0]  m_tuser;        // status [1:0]
	int          mismatches;
	int          pending;

	int          gap_max = 0;
	int          rx_max = 0;
	logic        hold_rx = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stable_priority_queue #(.DEPTH(Depth)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spq_checker #(.DEPTH(Depth)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	task automatic send(input op_t op, input logic [31:0] value, input logic [31:0] prio);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {prio, value};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int          n;
		int          phase;
		int          run_len;
		int          ins_pct;
		logic [31:0] prio;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remove on empty, then fill with extremes and ties
		send(OP_REMOVE, 32'h1234_5678, 32'h8765_4321);
		send(OP_INSERT, 32'h7fff_ffff, 32'h0000_0000);
		send(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
		send(OP_INSERT, 32'h0000_0001, 32'h7fff_ffff);
		send(OP_INSERT, 32'h0000_0002, 32'h8000_0000);
		send(OP_INSERT, 32'h0000_0003, 32'hffff_ffff);
		send(OP_INSERT, 32'h0000_0004, 32'h0000_0001);
		send(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		send(OP_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
		send(OP_INSERT, 32'h0000_0005, 32'h8000_0000);
		gap_max = 18;
		repeat (7) send(OP_INSERT, $urandom(), 32'(int'($urandom_range(0, 2)) - 1));
		// queue full now: this one is dropped
		send(OP_INSERT, 32'hdead_beef, 32'h8000_0000);
		repeat (4) send(OP_REMOVE, $urandom(), $urandom());
		drain();

		n = 0;
		phase = 0;
		while (n < 680) begin
			run_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: ins_pct = 85;
				1: ins_pct = 50;
				default: ins_pct = 15;
			endcase
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
			if (phase == 2) begin
				// long receiver hold with the sender flat out
				hold_rx = 1'b1;
				gap_max = 0;
				ins_pct = 85;
			end
			repeat (run_len) begin
				if ($urandom_range(0, 99) < ins_pct) begin
					// mostly a narrow band, so ties are common
					prio = ($urandom_range(0, 9) < 7) ? 32'(int'($urandom_range(0, 6)) - 3)
						: $urandom();
					send(OP_INSERT, $urandom(), prio);
				end else begin
					send(OP_REMOVE, $urandom(), $urandom());
				end
			end
			n += run_len;
			if (phase == 1 || $urandom_range(0, 3) == 0) begin
				drain();
			end
			phase++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_stable_priority_queue: clean");
		end else begin
			$display("tb_stable_priority_queue: errors");
		end
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				rx_max = (rx_max == 0) ? 18 : 0;
			end
			if (hold_rx) begin
				stall = 64;
				hold_rx = 1'b0;
			end else begin
				stall = $urandom_range(0, rx_max);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		#2_000_000;
		$display("tb_stable_priority_queue: errors");
		$finish;
	end

endmodule
